// ----- design/cwmf_pkg.sv -----
// ----------------------------------------------------------------------------
// cwmf_pkg
// Shared types and constants of the clipped-window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cwmf_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // job field widths cover the largest parameter values
    localparam int JOB_AW = 17;
    localparam int JOB_RW = 4;
    localparam int JOB_SW = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_RADIUS = 11'd1;
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 11'd480;

    typedef struct packed {
        logic [JOB_AW-1:0] addr;
        logic [JOB_RW-1:0] dy;
        logic [JOB_RW-1:0] dx;
        logic [JOB_SW-1:0] ny;
        logic [JOB_SW-1:0] nx;
        logic              last;
    } job_t;

endpackage

`default_nettype wire

// ----- design/cwmf_if.sv -----
// ----------------------------------------------------------------------------
// cwmf_if
// Valid/ready channels for pixel beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwmf_pixel_if;
    import cwmf_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [PIX_W-1:0] pixel_in;
    modport source (output valid, output command, output pixel_in, input ready);
    modport sink (input valid, input command, input pixel_in, output ready);
endinterface

interface cwmf_result_if;
    import cwmf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] median_pixel;
    logic             frame_end;
    modport source (output valid, output median_pixel, output frame_end, input ready);
    modport sink (input valid, input median_pixel, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/clipped_window_median_filter.sv -----
// ----------------------------------------------------------------------------
// clipped_window_median_filter
// Median over a border-clipped square window of 8-bit raster pixels.
//
// pixel_stream carries beats of {command, pixel_in}: command 0 writes the next
// raster pixel, command 1 is a drain beat that pushes out a pending result.
// median_stream carries {median_pixel, frame_end}; frame_end marks the last
// result of an image. Registers are written through cfg_we/cfg_index/cfg_data
// while idle; the user must keep to this, the block does not enforce it. A
// write restarts the image in progress. Each accepted beat causes at most one
// result. The result is found by a bitwise rank search over the clipped window
// (pixel count up to 225) that reads one line store word per cycle.
// A new beat is taken once the previous job has left the back end.
// Reset clears positions and restores register defaults; the line store is
// not cleared. A stalled receiver holds the result register and the back end
// waits, which in turn stops new beats.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_window_median_filter #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [cwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cwmf_pkg::CFG_DATA_W-1:0] cfg_data,
    cwmf_pixel_if.sink                           pixel_stream,
    cwmf_result_if.source                        median_stream
);
    import cwmf_pkg::*;

    localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    job_t               job, q_data;
    logic               push, pop, q_empty, q_full, back_idle, wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [PIX_W-1:0]   wr_data, rd_data;
    logic [$clog2(MAX_WIDTH):0] eff_w;

    cwmf_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_stream (pixel_stream),
        .back_idle    (back_idle),
        .q_empty      (q_empty),
        .push         (push),
        .job          (job),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .eff_w        (eff_w)
    );

    cwmf_queue #(
        .WIDTH ($bits(job_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    cwmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en && !q_full),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    cwmf_back #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .pop           (pop),
        .idle          (back_idle),
        .eff_w         (eff_w),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .median_stream (median_stream)
    );

endmodule

`default_nettype wire

// ----- design/cwmf_ram.sv -----
// ----------------------------------------------------------------------------
// cwmf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cwmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/cwmf_queue.sv -----
// ----------------------------------------------------------------------------
// cwmf_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cwmf_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty,
    output logic                  full
);

    logic [WIDTH-1:0] slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
            count_next  = count_next + 2'd1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            count_next  = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/cwmf_front.sv -----
// ----------------------------------------------------------------------------
// cwmf_front
// Registers, raster tracking, line store writes and job issue.
// ----------------------------------------------------------------------------
`default_nettype none

module cwmf_front #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [cwmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cwmf_pkg::CFG_DATA_W-1:0]    cfg_data,
    cwmf_pixel_if.sink                              pixel_stream,
    input  wire logic                               back_idle,
    input  wire logic                               q_empty,
    output logic                                    push,
    output cwmf_pkg::job_t                          job,
    output logic                                    wr_en,
    output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] wr_addr,
    output logic [cwmf_pkg::PIX_W-1:0]              wr_data,
    output logic [$clog2(MAX_WIDTH):0]              eff_w
);
    import cwmf_pkg::*;

    localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RADIUS+1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RH    = $clog2(MAX_HEIGHT);

    logic [CFG_DATA_W-1:0] radius_reg, width_reg, height_reg;
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RH-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [AW-1:0] in_addr_reg, in_addr_next, out_addr_reg, out_addr_next;
    logic          done_reg, done_next;

    logic [RW-1:0] r_eff;
    logic [RH:0]   h_eff;
    logic [RH+1:0] lr_sum, lr;
    logic [CW+1:0] lc_sum, lc;
    logic [RW-1:0] dy, dx;
    logic [RH:0]   y0;
    logic [CW:0]   x0;
    logic [RH+1:0] ny_full;
    logic [CW+1:0] nx_full;
    logic          accept, res_ready, last;

    assign r_eff = (int'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
    assign eff_w = (width_reg == '0) ? (CW+1)'(1) :
                   (int'(width_reg) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(width_reg);
    assign h_eff = (height_reg == '0) ? (RH+1)'(1) :
                   (int'(height_reg) > MAX_HEIGHT) ? (RH+1)'(MAX_HEIGHT) : (RH+1)'(height_reg);

    assign pixel_stream.ready = q_empty && back_idle;
    assign accept  = pixel_stream.valid && pixel_stream.ready;
    assign wr_addr = in_addr_reg;
    assign wr_data = pixel_stream.pixel_in;

    assign lr_sum = (RH+2)'(out_row_reg) + (RH+2)'(r_eff);
    assign lr     = (lr_sum > (RH+2)'(h_eff - 1'b1)) ? (RH+2)'(h_eff - 1'b1) : lr_sum;
    assign lc_sum = (CW+2)'(out_col_reg) + (CW+2)'(r_eff);
    assign lc     = (lc_sum > (CW+2)'(eff_w - 1'b1)) ? (CW+2)'(eff_w - 1'b1) : lc_sum;

    assign dy = (out_row_reg >= RH'(r_eff)) ? r_eff : RW'(out_row_reg);
    assign dx = (out_col_reg >= CW'(r_eff)) ? r_eff : RW'(out_col_reg);
    assign y0 = (RH+1)'(out_row_reg) - (RH+1)'(dy);
    assign x0 = (CW+1)'(out_col_reg) - (CW+1)'(dx);
    assign ny_full = lr - (RH+2)'(y0) + (RH+2)'(1);
    assign nx_full = lc - (CW+2)'(x0) + (CW+2)'(1);
    assign last = ((RH+1)'(out_row_reg) == h_eff - 1'b1) &&
                  ((CW+1)'(out_col_reg) == eff_w - 1'b1);

    assign job.addr = JOB_AW'(out_addr_reg);
    assign job.dy   = JOB_RW'(dy);
    assign job.dx   = JOB_RW'(dx);
    assign job.ny   = JOB_SW'(ny_full);
    assign job.nx   = JOB_SW'(nx_full);
    assign job.last = last;

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_addr_next  = in_addr_reg;
        done_next     = done_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_addr_next = out_addr_reg;
        wr_en         = 1'b0;
        push          = 1'b0;
        res_ready     = 1'b0;
        if (accept)
        begin
            if (!pixel_stream.command && !done_reg)
            begin
                wr_en        = 1'b1;
                in_addr_next = (in_addr_reg == AW'(DEPTH-1)) ? '0 : in_addr_reg + 1'b1;
                if ((CW+1)'(in_col_reg) == eff_w - 1'b1)
                begin
                    in_col_next = '0;
                    if ((RH+1)'(in_row_reg) == h_eff - 1'b1)
                    begin
                        in_row_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + 1'b1;
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            res_ready = done_next || ((RH+2)'(in_row_next) > lr) ||
                        (((RH+2)'(in_row_next) == lr) && ((CW+2)'(in_col_next) > lc));
            if (res_ready)
            begin
                push = 1'b1;
                if (last)
                begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_addr_next  = '0;
                    done_next     = 1'b0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_addr_next = '0;
                end
                else
                begin
                    out_addr_next = (out_addr_reg == AW'(DEPTH-1)) ? '0 : out_addr_reg + 1'b1;
                    if ((CW+1)'(out_col_reg) == eff_w - 1'b1)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RESET_RADIUS;
            width_reg    <= RESET_WIDTH;
            height_reg   <= RESET_HEIGHT;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_addr_reg  <= '0;
            done_reg     <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
        end
        else if (cfg_we && (cfg_index == CFG_RADIUS || cfg_index == CFG_IMAGE_WIDTH ||
                            cfg_index == CFG_IMAGE_HEIGHT))
        begin
            unique case (cfg_index)
                CFG_RADIUS:       radius_reg <= {{(CFG_DATA_W-3){1'b0}}, cfg_data[2:0]};
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          radius_reg <= radius_reg;
            endcase
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_addr_reg  <= '0;
            done_reg     <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_addr_reg  <= in_addr_next;
            done_reg     <= done_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_addr_reg <= out_addr_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/cwmf_back.sv -----
// ----------------------------------------------------------------------------
// cwmf_back
// Rank selection over the clipped window by bitwise search, one store read
// per cycle, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwmf_back #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     q_empty,
    input  cwmf_pkg::job_t                                q_data,
    output logic                                          pop,
    output logic                                          idle,
    input  wire logic [$clog2(MAX_WIDTH):0]               eff_w,
    output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] rd_addr,
    input  wire logic [cwmf_pkg::PIX_W-1:0]               rd_data,
    cwmf_result_if.source                                 median_stream
);
    import cwmf_pkg::*;

    localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RADIUS+1);
    localparam int SW    = $clog2(2*MAX_RADIUS+2);
    localparam int WW    = $clog2(MAX_WIDTH) + 1;
    localparam int NW    = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1);
    localparam int MW    = RW + WW + 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETUP1 = 7'b0000010,
        ST_SETUP2 = 7'b0000100,
        ST_SWEEP  = 7'b0001000,
        ST_FLUSH  = 7'b0010000,
        ST_EVAL   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    job_t           job_reg;
    logic [MW-1:0]  off_reg;
    logic [NW-1:0]  n_reg;
    logic [AW-1:0]  base_reg, base_next;
    logic [AW-1:0]  row_reg, row_next;
    logic [AW-1:0]  cur_reg, cur_next;
    logic [SW-1:0]  x_reg, x_next, y_reg, y_next;
    logic           rd_vld_reg;
    logic [NW-1:0]  cnt_reg, cnt_next;
    logic [PIX_W-1:0] prefix_reg, prefix_next, lo_reg, lo_next;
    logic [2:0]     bit_reg, bit_next;
    logic           pass_reg, pass_next;
    logic           out_vld_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic           out_last_reg;

    logic [PIX_W-1:0] cand, eval_prefix;
    logic [NW-1:0]    rank;
    logic [AW:0]      row_sum, cur_sum;
    logic [AW:0]      base_calc;
    logic [PIX_W:0]   mean_sum;
    logic             load_out;

    assign idle    = (state_reg == ST_IDLE);
    assign pop     = idle && !q_empty;
    assign rd_addr = cur_reg;
    assign cand    = prefix_reg | (PIX_W'(1) << bit_reg);
    assign rank    = pass_reg ? (n_reg >> 1) : ((n_reg - 1'b1) >> 1);
    assign eval_prefix = (cnt_reg <= rank) ? cand : prefix_reg;
    assign mean_sum    = (PIX_W+1)'(lo_reg) + (PIX_W+1)'(eval_prefix);
    assign row_sum = (AW+1)'(row_reg) + (AW+1)'(eff_w);
    assign cur_sum = (AW+1)'(cur_reg) + (AW+1)'(1);
    assign base_calc = ((AW+1)'(job_reg.addr) >= (AW+1)'(off_reg)) ?
                       (AW+1)'(job_reg.addr) - (AW+1)'(off_reg) :
                       (AW+1)'(job_reg.addr) + (AW+1)'(DEPTH) - (AW+1)'(off_reg);
    assign load_out = (state_reg == ST_DONE) && (!out_vld_reg || median_stream.ready);

    assign median_stream.valid        = out_vld_reg;
    assign median_stream.median_pixel = out_pix_reg;
    assign median_stream.frame_end    = out_last_reg;

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        row_next    = row_reg;
        cur_next    = cur_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        cnt_next    = cnt_reg;
        prefix_next = prefix_reg;
        lo_next     = lo_reg;
        bit_next    = bit_reg;
        pass_next   = pass_reg;
        if (rd_vld_reg && (rd_data < cand))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_SETUP1;
                end
            end
            ST_SETUP1:
            begin
                state_next = ST_SETUP2;
            end
            ST_SETUP2:
            begin
                base_next   = AW'(base_calc);
                row_next    = AW'(base_calc);
                cur_next    = AW'(base_calc);
                x_next      = '0;
                y_next      = '0;
                cnt_next    = '0;
                prefix_next = '0;
                bit_next    = 3'd7;
                pass_next   = 1'b0;
                state_next  = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (x_reg == SW'(job_reg.nx) - 1'b1)
                begin
                    x_next = '0;
                    if (y_reg == SW'(job_reg.ny) - 1'b1)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        y_next   = y_reg + 1'b1;
                        row_next = (row_sum >= (AW+1)'(DEPTH)) ?
                                   AW'(row_sum - (AW+1)'(DEPTH)) : AW'(row_sum);
                        cur_next = row_next;
                    end
                end
                else
                begin
                    x_next   = x_reg + 1'b1;
                    cur_next = (cur_sum >= (AW+1)'(DEPTH)) ? '0 : AW'(cur_sum);
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                row_next    = base_reg;
                cur_next    = base_reg;
                x_next      = '0;
                y_next      = '0;
                cnt_next    = '0;
                prefix_next = eval_prefix;
                bit_next    = bit_reg - 1'b1;
                state_next  = ST_SWEEP;
                if (bit_reg == 3'd0)
                begin
                    if (!pass_reg)
                    begin
                        lo_next     = eval_prefix;
                        pass_next   = 1'b1;
                        prefix_next = '0;
                        bit_next    = 3'd7;
                    end
                    else
                    begin
                        lo_next    = PIX_W'(mean_sum >> 1);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SWEEP);
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (median_stream.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_data;
        end
        if (state_reg == ST_SETUP1)
        begin
            off_reg <= MW'(RW'(job_reg.dy) * eff_w) + MW'(RW'(job_reg.dx));
            n_reg   <= NW'(SW'(job_reg.ny) * SW'(job_reg.nx));
        end
        if (load_out)
        begin
            out_pix_reg  <= lo_reg;
            out_last_reg <= job_reg.last;
        end
        base_reg   <= base_next;
        row_reg    <= row_next;
        cur_reg    <= cur_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        cnt_reg    <= cnt_next;
        prefix_reg <= prefix_next;
        lo_reg     <= lo_next;
        bit_reg    <= bit_next;
        pass_reg   <= pass_next;
    end

endmodule

`default_nettype wire

// ----- dv/clipped_window_median_filter_tb.sv -----
// ----------------------------------------------------------------------------
// clipped_window_median_filter_tb
// Self-checking bench for the clipped-window median filter. A behavioural
// model of the line store and raster positions predicts every median and
// frame marker; directed frames cover register extremes, clamping, drain
// beats, pixels after image end and even window counts, then random frames
// run under three settings of source and sink stalls, the last without stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_window_median_filter_tb;
    import cwmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRED_MAX_R  = 7;
    localparam int PRED_MAX_W  = 1024;
    localparam int PRED_MAX_H  = 1024;
    localparam int STORE_DEPTH = (2 * PRED_MAX_R + 1) * PRED_MAX_W;
    localparam int SETTLE      = 4000;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam bit CMD_PIXEL = 1'b0;
    localparam bit CMD_DRAIN = 1'b1;

    typedef struct {
        logic [PIX_W-1:0] median_pixel;
        logic             frame_end;
    } median_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cwmf_pixel_if  pix_if ();
    cwmf_result_if res_if ();

    clipped_window_median_filter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_stream  (pix_if),
        .median_stream (res_if)
    );

    // filter model state
    logic [PIX_W-1:0] line_mem [STORE_DEPTH];
    logic [2:0]       m_radius;
    logic [10:0]      m_width;
    logic [10:0]      m_height;
    int unsigned      in_row, in_col, out_row, out_col;
    bit               in_done;

    median_beat_t pending_medians[$];
    int           errors;
    int           items_sent;
    int           send_idle_pct;
    int           recv_idle_pct;
    longint       cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** clipped_window_median_filter: FAILED **");
            $finish;
        end
    end

    function automatic int unsigned eff_r();
        return (m_radius > PRED_MAX_R) ? PRED_MAX_R : m_radius;
    endfunction

    function automatic int unsigned eff_w();
        if (m_width < 1) return 1;
        return (m_width > PRED_MAX_W) ? PRED_MAX_W : m_width;
    endfunction

    function automatic int unsigned eff_h();
        if (m_height < 1) return 1;
        return (m_height > PRED_MAX_H) ? PRED_MAX_H : m_height;
    endfunction

    function automatic void restart_image();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        in_done = 0;
    endfunction

    function automatic int unsigned value_at_rank(ref int hist[256], input int unsigned rk);
        int unsigned acc;
        acc = 0;
        for (int v = 0; v < 256; v++)
        begin
            acc += hist[v];
            if (acc > rk) return v;
        end
        return 255;
    endfunction

    function automatic logic [PIX_W-1:0] clipped_median();
        int          hist[256];
        int unsigned r, w, h, y0, x0, y1, x1, n;
        r = eff_r(); w = eff_w(); h = eff_h();
        y0 = (out_row >= r) ? out_row - r : 0;
        x0 = (out_col >= r) ? out_col - r : 0;
        y1 = (out_row + r > h - 1) ? h - 1 : out_row + r;
        x1 = (out_col + r > w - 1) ? w - 1 : out_col + r;
        foreach (hist[i]) hist[i] = 0;
        for (int unsigned y = y0; y <= y1; y++)
            for (int unsigned x = x0; x <= x1; x++)
                hist[line_mem[(y * w + x) % STORE_DEPTH]]++;
        n = (y1 - y0 + 1) * (x1 - x0 + 1);
        if (n % 2 == 1) return PIX_W'(value_at_rank(hist, n / 2));
        return PIX_W'((value_at_rank(hist, n / 2 - 1) + value_at_rank(hist, n / 2)) / 2);
    endfunction

    function automatic void predict_beat(bit cmd, logic [PIX_W-1:0] px);
        int unsigned  w, h, r, lr, lc;
        median_beat_t exp_beat;
        bit           last;
        w = eff_w(); h = eff_h(); r = eff_r();
        if (cmd == CMD_PIXEL && !in_done)
        begin
            line_mem[(in_row * w + in_col) % STORE_DEPTH] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    in_done = 1;
                end
            end
        end
        lr = (out_row + r > h - 1) ? h - 1 : out_row + r;
        lc = (out_col + r > w - 1) ? w - 1 : out_col + r;
        if (!(in_done || in_row > lr || (in_row == lr && in_col > lc)))
            return;
        last = (out_row == h - 1) && (out_col == w - 1);
        exp_beat.median_pixel = clipped_median();
        exp_beat.frame_end    = last;
        pending_medians = {pending_medians, exp_beat};
        if (last)
            restart_image();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // called and returns at a falling edge
    task automatic send_beat(input bit cmd, input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid = 1'b0;
            @(negedge clk);
        end
        pix_if.valid    = 1'b1;
        pix_if.command  = cmd;
        pix_if.pixel_in = px;
        do @(posedge clk); while (!pix_if.ready);
        predict_beat(cmd, px);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pix_if.valid = 1'b0;
        while (pending_medians.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_RADIUS:       m_radius = val[2:0];
            CFG_IMAGE_WIDTH:  m_width  = val;
            CFG_IMAGE_HEIGHT: m_height = val;
            default: ;
        endcase
        restart_image();
    endtask

    task automatic set_geometry(input int r, input int w, input int h);
        wait_idle();
        write_reg(CFG_RADIUS, CFG_DATA_W'(r));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic drain_image();
        while (in_done) send_beat(CMD_DRAIN, PIX_W'($urandom_range(255)));
    endtask

    // sink: checks each median beat
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_medians.size() == 0)
            begin
                $error("median beat with nothing expected: median_pixel %0d frame_end %0d",
                       res_if.median_pixel, res_if.frame_end);
                errors++;
            end
            else
            begin
                median_beat_t e;
                e = pending_medians.pop_front();
                if (res_if.median_pixel !== e.median_pixel)
                begin
                    $error("median_pixel: expected %0d, got %0d",
                           e.median_pixel, res_if.median_pixel);
                    errors++;
                end
                if (res_if.frame_end !== e.frame_end)
                begin
                    $error("frame_end: expected %0d, got %0d", e.frame_end, res_if.frame_end);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic test_single_pixel_frames();
        set_geometry(0, 1, 1);
        send_beat(CMD_PIXEL, 8'd0);
        send_beat(CMD_PIXEL, 8'd255);
        send_beat(CMD_DRAIN, 8'd0);
        send_beat(CMD_PIXEL, 8'hA5);
    endtask

    task automatic test_drain_and_late_pixels();
        set_geometry(1, 3, 3);
        send_beat(CMD_DRAIN, 8'd17);
        for (int i = 0; i < 9; i++)
            send_beat(CMD_PIXEL, (i % 2) ? 8'd255 : 8'd0);
        send_beat(CMD_PIXEL, 8'd77);
        send_beat(CMD_PIXEL, 8'd200);
        drain_image();
    endtask

    task automatic test_even_windows();
        set_geometry(1, 2, 2);
        send_beat(CMD_PIXEL, 8'd0);
        send_beat(CMD_PIXEL, 8'd255);
        send_beat(CMD_PIXEL, 8'd1);
        send_beat(CMD_PIXEL, 8'd254);
        drain_image();
    endtask

    task automatic test_register_extremes();
        set_geometry(7, 1024, 1);
        repeat (12) send_beat(CMD_PIXEL, PIX_W'($urandom_range(255)));
        set_geometry(7, 0, 2047);
        repeat (12) send_beat(CMD_PIXEL, PIX_W'($urandom_range(255)));
        set_geometry(7, 2047, 0);
        repeat (10) send_beat(CMD_PIXEL, PIX_W'($urandom_range(255)));
        set_geometry(7, 1024, 1024);
        repeat (6) send_beat(CMD_PIXEL, PIX_W'($urandom_range(255)));
        set_geometry(7, 4, 3);
        repeat (12) send_beat(CMD_PIXEL, PIX_W'($urandom_range(255)));
        drain_image();
    endtask

    task automatic test_random_frames(input int s_pct, input int r_pct, input int target);
        int stop_at, w, h, npix;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
            h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
            set_geometry($urandom_range(7), w, h);
            npix = eff_w() * eff_h();
            if ($urandom_range(9) == 0)
                npix = $urandom_range(npix);
            for (int i = 0; i < npix; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_beat(CMD_DRAIN, PIX_W'($urandom_range(255)));
                if ($urandom_range(49) == 0)
                    wait_idle();
                case ($urandom_range(7))
                    0: send_beat(CMD_PIXEL, 8'd0);
                    1: send_beat(CMD_PIXEL, 8'd255);
                    default: send_beat(CMD_PIXEL, PIX_W'($urandom_range(255)));
                endcase
            end
            drain_image();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_RADIUS;
        cfg_data         = '0;
        pix_if.valid     = 1'b0;
        pix_if.command   = CMD_PIXEL;
        pix_if.pixel_in  = '0;
        res_if.ready     = 1'b0;
        errors           = 0;
        items_sent       = 0;
        cycle_count      = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        m_radius         = RESET_RADIUS[2:0];
        m_width          = RESET_WIDTH;
        m_height         = RESET_HEIGHT;
        foreach (line_mem[i]) line_mem[i] = '0;
        restart_image();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_pixel_frames();
        test_drain_and_late_pixels();
        test_even_windows();
        test_register_extremes();
        test_random_frames(32, 85, 120);
        test_random_frames(85, 32, 120);
        test_random_frames(0, 0, 120);

        wait_idle();
        if (errors == 0)
            $display("** clipped_window_median_filter: PASSED **");
        else
            $display("** clipped_window_median_filter: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ----- clipped_window_median_filter.f -----
design/cwmf_pkg.sv
design/cwmf_if.sv
design/cwmf_ram.sv
design/cwmf_queue.sv
design/cwmf_front.sv
design/cwmf_back.sv
design/clipped_window_median_filter.sv
dv/clipped_window_median_filter_tb.sv
